/* src/ccpg_pkg.sv */
package ccpg_pkg;

  localparam int PT_W   = 32;
  localparam int COEF_W = 40;
  localparam int N_W    = 6;

  typedef enum logic {
    OP_BEZIER  = 1'b0,
    OP_HERMITE = 1'b1
  } curve_op_e;

  typedef struct packed {
    logic                   op;
    logic signed [PT_W-1:0] pt0_x;
    logic signed [PT_W-1:0] pt0_y;
    logic signed [PT_W-1:0] pt1_x;
    logic signed [PT_W-1:0] pt1_y;
    logic signed [PT_W-1:0] pt2_x;
    logic signed [PT_W-1:0] pt2_y;
    logic signed [PT_W-1:0] pt3_x;
    logic signed [PT_W-1:0] pt3_y;
    logic [N_W-1:0]         step_count;
  } ccpg_req_t;

  typedef struct packed {
    logic signed [PT_W-1:0] vert_x;
    logic signed [PT_W-1:0] vert_y;
    logic                   last_vertex;
  } ccpg_vert_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  // index k holds the coefficient of t^k
  typedef coef_t [3:0] coef4_t;

  typedef struct packed {
    coef4_t         cx;
    coef4_t         cy;
    logic [N_W-1:0] n;
  } ccpg_curve_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } ccpg_head_ctl_t;

  function automatic coef4_t make_coefs(input logic hermite, input logic signed [PT_W-1:0] a,
                                        input logic signed [PT_W-1:0] b,
                                        input logic signed [PT_W-1:0] c,
                                        input logic signed [PT_W-1:0] d);
    coef_t  p0, p1, p2, p3;
    coef4_t r;
    p0 = COEF_W'(a);
    p1 = COEF_W'(b);
    p2 = COEF_W'(c);
    p3 = COEF_W'(d);
    if (hermite == OP_HERMITE) begin
      r[3] = (p0 <<< 1) - (p1 <<< 1) + p2 + p3;
      r[2] = (p1 - p0) * 3 - (p2 <<< 1) - p3;
      r[1] = p2;
    end else begin
      r[3] = (p1 - p2) * 3 + p3 - p0;
      r[2] = (p0 - (p1 <<< 1) + p2) * 3;
      r[1] = (p1 - p0) * 3;
    end
    r[0] = p0;
    return r;
  endfunction

endpackage

/* src/ccpg_front.sv */
module ccpg_front import ccpg_pkg::*; #(
  parameter int MAX_STEPS = 63
) (
  input  ccpg_req_t   req_i,
  output ccpg_curve_t curve_o
);

  logic [N_W-1:0] n;

  always_comb begin
    if (req_i.step_count == '0) begin
      n = N_W'(1);
    end else if (req_i.step_count > N_W'(MAX_STEPS)) begin
      n = N_W'(MAX_STEPS);
    end else begin
      n = req_i.step_count;
    end
  end

  assign curve_o.cx = make_coefs(req_i.op, req_i.pt0_x, req_i.pt1_x, req_i.pt2_x, req_i.pt3_x);
  assign curve_o.cy = make_coefs(req_i.op, req_i.pt0_y, req_i.pt1_y, req_i.pt2_y, req_i.pt3_y);
  assign curve_o.n  = n;

endmodule

/* src/ccpg_queue.sv */
module ccpg_queue import ccpg_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ccpg_curve_t    data_i,
  output logic           full_o,
  input  ccpg_head_ctl_t ctl_i,
  output logic           head_valid_o,
  output ccpg_curve_t    head_o
);

  ccpg_curve_t mem_q [2];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = ctl_i.pop && ctl_i.valid;

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* src/ccpg_back.sv */
module ccpg_back import ccpg_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  ccpg_curve_t    head_i,
  output ccpg_head_ctl_t ctl_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ccpg_vert_t     out_o
);

  localparam int TW = FRAC_BITS + 1;
  localparam int AW = 42;
  localparam int PW = AW + TW + 1;
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam logic signed [AW-1:0] SAT_MAX = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] SAT_MIN = -AW'(64'sd2147483648);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } back_state_e;

  typedef logic signed [AW-1:0] acc_t;
  typedef logic signed [PW-1:0] prod_t;

  function automatic acc_t rnd(input prod_t p);
    prod_t s;
    s = (p + (PW'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return s[AW-1:0];
  endfunction

  function automatic acc_t ext(input coef_t c);
    return {{(AW-COEF_W){c[COEF_W-1]}}, c};
  endfunction

  function automatic prod_t mul(input acc_t a, input logic [TW-1:0] t);
    return PW'(a) * $signed({1'b0, t});
  endfunction

  function automatic logic [PT_W-1:0] sat(input acc_t r);
    acc_t v;
    v = r;
    if (r > SAT_MAX) v = SAT_MAX;
    if (r < SAT_MIN) v = SAT_MIN;
    return v[PT_W-1:0];
  endfunction

  back_state_e     state_q, state_d;
  logic [CW-1:0]   dcnt_q, dcnt_d;
  logic [N_W-1:0]  drem_q, drem_d;
  logic [TW-1:0]   quot_q, quot_d;
  logic [N_W-1:0]  idx_q, idx_d;
  logic [TW-1:0]   t_q, t_d;
  logic [N_W-1:0]  trem_q, trem_d;

  logic [N_W:0]    dtry, tsum;
  logic [N_W-1:0]  n;
  logic            en, issue;

  // pipeline: s0 issue, s1 mul c3, s2 add c2, s3 mul, s4 add c1, s5 mul, out add c0
  logic [5:0]      v_q;
  logic [5:0]      l_q;
  logic [TW-1:0]   t0_q, t1_q, t2_q, t3_q, t4_q;
  prod_t           mx1_q, my1_q, mx3_q, my3_q, mx5_q, my5_q;
  acc_t            ax2_q, ay2_q, ax4_q, ay4_q;
  logic            ovalid_q;
  ccpg_vert_t      out_q;

  assign n     = head_i.n;
  assign en    = !(ovalid_q && out_stall_i);
  assign issue = (state_q == ST_RUN) && en;

  assign ctl_o.valid = head_valid_i;
  assign ctl_o.pop   = en && v_q[5] && l_q[5];
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d = state_q;
    dcnt_d  = dcnt_q;
    drem_d  = drem_q;
    quot_d  = quot_q;
    idx_d   = idx_q;
    t_d     = t_q;
    trem_d  = trem_q;
    dtry    = {drem_q, (dcnt_q == CW'(FRAC_BITS))};
    tsum    = {1'b0, trem_q} + {1'b0, drem_q};
    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          dcnt_d  = CW'(FRAC_BITS);
          drem_d  = '0;
          quot_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring division of 2^FRAC_BITS by n, one quotient bit per cycle
        if (dtry >= {1'b0, n}) begin
          drem_d = N_W'(dtry - {1'b0, n});
          quot_d = {quot_q[TW-2:0], 1'b1};
        end else begin
          drem_d = dtry[N_W-1:0];
          quot_d = {quot_q[TW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - CW'(1);
        if (dcnt_q == '0) begin
          idx_d   = '0;
          t_d     = '0;
          trem_d  = n >> 1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        // drem now holds 2^F mod n; step t = round(i*2^F/n) incrementally
        if (en) begin
          idx_d = idx_q + N_W'(1);
          if (tsum >= {1'b0, n}) begin
            t_d    = t_q + quot_q + TW'(1);
            trem_d = N_W'(tsum - {1'b0, n});
          end else begin
            t_d    = t_q + quot_q;
            trem_d = tsum[N_W-1:0];
          end
          if (idx_q == n) state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (ctl_o.pop) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      v_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (en) begin
        v_q      <= {v_q[4:0], issue};
        ovalid_q <= v_q[5];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dcnt_q <= dcnt_d;
    drem_q <= drem_d;
    quot_q <= quot_d;
    idx_q  <= idx_d;
    t_q    <= t_d;
    trem_q <= trem_d;
    if (en) begin
      l_q   <= {l_q[4:0], (idx_q == n)};
      t0_q  <= t_q;
      t1_q  <= t0_q;
      t2_q  <= t1_q;
      t3_q  <= t2_q;
      t4_q  <= t3_q;
      mx1_q <= mul(ext(head_i.cx[3]), t0_q);
      my1_q <= mul(ext(head_i.cy[3]), t0_q);
      ax2_q <= rnd(mx1_q) + ext(head_i.cx[2]);
      ay2_q <= rnd(my1_q) + ext(head_i.cy[2]);
      mx3_q <= mul(ax2_q, t2_q);
      my3_q <= mul(ay2_q, t2_q);
      ax4_q <= rnd(mx3_q) + ext(head_i.cx[1]);
      ay4_q <= rnd(my3_q) + ext(head_i.cy[1]);
      mx5_q <= mul(ax4_q, t4_q);
      my5_q <= mul(ay4_q, t4_q);
      out_q.vert_x      <= sat(rnd(mx5_q) + ext(head_i.cx[0]));
      out_q.vert_y      <= sat(rnd(my5_q) + ext(head_i.cy[0]));
      out_q.last_vertex <= l_q[5];
    end
  end

endmodule

/* src/cubic_curve_point_generator_core.sv */
// Cubic Bezier/Hermite curve point generator. Each request carries four
// Q16.16 points and a step count n (0 is taken as 1, values above MAX_STEPS
// are clamped); the block emits n+1 saturated vertices, the last one flagged.
// A front stage converts the points to power-basis coefficients and writes a
// two-deep curve queue. The running curve stays at the queue head, so one
// further request is taken while a curve runs. The back end picks up the head
// in its idle state, then divides 2^FRAC_BITS by n, one bit per cycle, then
// issues one vertex per cycle, unless the output stalls, into a six-stage
// Horner pipeline, one multiplier per step and axis, and drains it before the
// next curve. An output stall freezes the whole pipeline.
module cubic_curve_point_generator_core import ccpg_pkg::*; #(
  parameter int MAX_STEPS = 63,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ccpg_req_t  in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output ccpg_vert_t out_vert_o
);

  ccpg_curve_t    curve, head;
  ccpg_head_ctl_t ctl;
  logic           full, head_valid;

  assign in_stall_o = full;

  ccpg_front #(
    .MAX_STEPS(MAX_STEPS)
  ) u_front (
    .req_i  (in_req_i),
    .curve_o(curve)
  );

  ccpg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .data_i      (curve),
    .full_o      (full),
    .ctl_i       (ctl),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  ccpg_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .ctl_o       (ctl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_vert_o)
  );

endmodule

/* src/ccpg_checker.sv */
module ccpg_checker import ccpg_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input ccpg_vert_t out_vert_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_vert_o))
    else $error("output changed while stalled");

  // every curve has at least two vertices, so a burst never opens on the last one
  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !out_vert_o.last_vertex)
    else $error("curve began with its last vertex");

  // the next curve needs its divide setup, so a gap follows every last vertex
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_vert_o.last_vertex |=> !out_valid_o)
    else $error("vertex right after last vertex");

endmodule

bind cubic_curve_point_generator_core ccpg_checker u_ccpg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_vert_o (out_vert_o)
);

/* dv/cubic_curve_point_generator_core_tb.sv */
module cubic_curve_point_generator_core_tb;
  import ccpg_pkg::*;

  localparam int FRAC = 16;
  localparam int STEP_CAP = 63;
  localparam int HANG_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  ccpg_req_t  in_req;
  logic       out_valid;
  logic       out_stall;
  ccpg_vert_t out_vert;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int idle_cycles;

  ccpg_vert_t vertex_queue[$];

  cubic_curve_point_generator_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_vert_o (out_vert)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // round(acc * t / 2^FRAC), halves toward +inf
  function automatic longint scale_by_t(longint acc, longint t);
    longint p;
    p = acc * t + (longint'(1) <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  function automatic logic signed [31:0] horner_axis(longint c3, longint c2, longint c1,
                                                     longint c0, longint t);
    longint r;
    r = c3;
    r = scale_by_t(r, t) + c2;
    r = scale_by_t(r, t) + c1;
    r = scale_by_t(r, t) + c0;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic void power_coefs(logic hermite, longint p0, longint p1, longint p2,
                                      longint p3, output longint c[4]);
    if (hermite == OP_HERMITE) begin
      c[3] = 2 * p0 - 2 * p1 + p2 + p3;
      c[2] = -3 * p0 + 3 * p1 - 2 * p2 - p3;
      c[1] = p2;
    end else begin
      c[3] = -p0 + 3 * p1 - 3 * p2 + p3;
      c[2] = 3 * p0 - 6 * p1 + 3 * p2;
      c[1] = -3 * p0 + 3 * p1;
    end
    c[0] = p0;
  endfunction

  task automatic predict_vertices(ccpg_req_t rq);
    longint cx[4];
    longint cy[4];
    longint n;
    longint t;
    ccpg_vert_t v;
    n = rq.step_count;
    if (n == 0) n = 1;
    if (n > STEP_CAP) n = STEP_CAP;
    power_coefs(rq.op, rq.pt0_x, rq.pt1_x, rq.pt2_x, rq.pt3_x, cx);
    power_coefs(rq.op, rq.pt0_y, rq.pt1_y, rq.pt2_y, rq.pt3_y, cy);
    for (longint i = 0; i <= n; i++) begin
      t = ((i <<< FRAC) + (n >>> 1)) / n;
      v.vert_x = horner_axis(cx[3], cx[2], cx[1], cx[0], t);
      v.vert_y = horner_axis(cy[3], cy[2], cy[1], cy[0], t);
      v.last_vertex = (i == n);
      vertex_queue.push_back(v);
    end
  endtask

  task automatic report_mismatch(string what);
    mismatches++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  // called at a falling edge; valid stays high into the next request when there is no idle gap
  task automatic send_request(ccpg_req_t rq);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_req   <= rq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_vertices(rq);
    @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > HANG_LIMIT) begin
        $display("cubic_curve_point_generator_core test failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (vertex_queue.size() == 0) begin
          report_mismatch("vertex with no request pending");
        end else begin
          ccpg_vert_t e;
          e = vertex_queue.pop_front();
          if (out_vert.vert_x !== e.vert_x)
            report_mismatch($sformatf("vert_x %h exp %h", out_vert.vert_x, e.vert_x));
          if (out_vert.vert_y !== e.vert_y)
            report_mismatch($sformatf("vert_y %h exp %h", out_vert.vert_y, e.vert_y));
          if (out_vert.last_vertex !== e.last_vertex)
            report_mismatch($sformatf("last_vertex %b exp %b", out_vert.last_vertex,
                                      e.last_vertex));
        end
      end
    end
  end

  function automatic logic signed [31:0] pick_coord(int mode);
    case (mode)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'(signed'($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      default: return $urandom;
    endcase
  endfunction

  function automatic ccpg_req_t random_request(int wide);
    ccpg_req_t rq;
    rq.op = curve_op_e'($urandom_range(1));
    rq.pt0_x = pick_coord(wide ? $urandom_range(3) : 2 + $urandom_range(1));
    rq.pt0_y = pick_coord(wide ? $urandom_range(3) : 2 + $urandom_range(1));
    rq.pt1_x = pick_coord(wide ? $urandom_range(3) : 2 + $urandom_range(1));
    rq.pt1_y = pick_coord(wide ? $urandom_range(3) : 2 + $urandom_range(1));
    rq.pt2_x = pick_coord(wide ? $urandom_range(3) : 2 + $urandom_range(1));
    rq.pt2_y = pick_coord(wide ? $urandom_range(3) : 2 + $urandom_range(1));
    rq.pt3_x = pick_coord(wide ? $urandom_range(3) : 2 + $urandom_range(1));
    rq.pt3_y = pick_coord(wide ? $urandom_range(3) : 2 + $urandom_range(1));
    // mostly short curves, a few long ones and the zero count
    case ($urandom_range(9))
      0: rq.step_count = 6'd0;
      1: rq.step_count = 6'(STEP_CAP);
      2, 3: rq.step_count = 6'($urandom_range(STEP_CAP));
      default: rq.step_count = 6'($urandom_range(1, 8));
    endcase
    return rq;
  endfunction

  task automatic test_directed();
    ccpg_req_t rq;
    logic signed [31:0] ext[3];
    ext[0] = 32'sh7fffffff;
    ext[1] = 32'sh80000000;
    ext[2] = 32'sh0;
    foreach (ext[k]) begin
      for (int o = 0; o < 2; o++) begin
        rq.op = curve_op_e'(o);
        rq.pt0_x = ext[k];  rq.pt0_y = ~ext[k];
        rq.pt1_x = ~ext[k]; rq.pt1_y = ext[k];
        rq.pt2_x = ext[k];  rq.pt2_y = ~ext[k];
        rq.pt3_x = ~ext[k]; rq.pt3_y = ext[k];
        rq.step_count = (k == 0) ? 6'd63 : (k == 1) ? 6'd0 : 6'd1;
        send_request(rq);
      end
    end
    // step counts at the edges (0 and 63) and two small ones, plus saturating tangents
    for (int s = 0; s < 6; s++) begin
      rq = random_request(1);
      rq.op = (s % 2) ? OP_HERMITE : OP_BEZIER;
      rq.step_count = (s < 2) ? 6'd0 : (s < 4) ? 6'd63 : 6'(s);
      send_request(rq);
    end
    rq = random_request(0);
    rq.op = OP_HERMITE;
    rq.pt2_x = 32'sh7fffffff; rq.pt3_x = 32'sh7fffffff;
    rq.pt2_y = 32'sh80000000; rq.pt3_y = 32'sh80000000;
    rq.step_count = 6'd7;
    send_request(rq);
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) send_request(random_request($urandom_range(3) == 0));
  endtask

  initial begin
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatches = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 88;
    test_directed();
    test_random(145);
    send_idle_pct = 88;
    recv_idle_pct = 27;
    test_random(145);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    in_valid <= 1'b0;

    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (mismatches == 0 && vertex_queue.size() == 0) begin
      $display("cubic_curve_point_generator_core test passed");
    end else begin
      $display("cubic_curve_point_generator_core test failed");
    end
    $finish;
  end

endmodule
